// ===== hw/rtl/vks_pkg.sv =====
// Shared types, constants and fixed-point helpers for the kinematic step core
package vks_pkg;

   localparam int PC_W   = 5;
   localparam int CNT_W  = 5;
   localparam int CSR_AW = 4;

   localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
   localparam logic [PC_W-1:0] PC_LAG   = 5'd1;
   localparam logic [PC_W-1:0] PC_CLAMP = 5'd4;
   localparam logic [PC_W-1:0] PC_ITER  = 5'd13;
   localparam logic [PC_W-1:0] PC_LAST  = 5'd17;

   localparam logic [CNT_W-1:0] LOOP_LAST    = 5'd23;
   localparam logic [CNT_W-1:0] CORDIC_STEPS = 5'd16;

   localparam logic [24:0]        DEG360   = 25'd23592960;
   localparam logic signed [25:0] DEG90_S  = 26'sd5898240;
   localparam logic signed [25:0] DEG180_S = 26'sd11796480;
   localparam logic signed [25:0] DEG270_S = 26'sd17694720;
   localparam logic signed [25:0] DEG360_S = 26'sd23592960;
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [31:0] DEADBAND = 32'sd6554;

   localparam logic signed [31:0] RST_FWD_SPEED   = 32'sd655360;
   localparam logic signed [31:0] RST_BWD_SPEED   = -32'sd655360;
   localparam logic signed [31:0] RST_LEFT_STEER  = -32'sd1966080;
   localparam logic signed [31:0] RST_RIGHT_STEER = 32'sd1966080;

   typedef enum logic [1:0] {
      REG_FWD_SPEED,
      REG_BWD_SPEED,
      REG_LEFT_STEER,
      REG_RIGHT_STEER
   } csr_reg_type;

   typedef struct packed {
      logic               kind;
      logic [15:0]        time_step;
      logic signed [31:0] target_speed;
      logic signed [31:0] target_steering;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_z;
      logic [24:0]        heading;
      logic signed [31:0] cur_speed;
      logic signed [31:0] cur_steering;
   } rsp_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_LAG_SPD,
      MUL_LAG_STR,
      MUL_SPD_DT,
      MUL_TURN,
      MUL_TURN_LO,
      MUL_TURN_HI,
      MUL_XC,
      MUL_ZS
   } mul_sel_type;

   typedef enum logic [3:0] {
      ALU_NOP,
      ALU_LAG_SPD,
      ALU_LAG_STR,
      ALU_CLAMP_INIT,
      ALU_D_LOAD,
      ALU_T1_LOAD,
      ALU_ACC_LO,
      ALU_ACC_HI,
      ALU_HEAD_ADD,
      ALU_WRAP_INIT,
      ALU_ITER,
      ALU_HEAD_FIX,
      ALU_X_ACC,
      ALU_Z_ACC,
      ALU_FINISH
   } alu_op_type;

   typedef enum logic [2:0] {
      J_NEXT,
      J_GOTO,
      J_IF_KIND0,
      J_LOOP,
      J_WAIT_REQ,
      J_WAIT_OUT
   } jump_type;

   typedef struct packed {
      mul_sel_type      mul_sel;
      alu_op_type       alu_op;
      jump_type         jump;
      logic [PC_W-1:0]  target;
   } ctl_word_type;

   typedef struct packed {
      logic req_valid;
      logic kind0;
      logic out_free;
   } cond_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = $signed(v[31:0]);
      end
      return r;
   endfunction

   // either-order clamp of n between a and b
   function automatic logic signed [31:0] limit(input logic signed [31:0] a,
                                                input logic signed [31:0] n,
                                                input logic signed [31:0] b);
      logic signed [31:0] r;
      r = n;
      if (a < b) begin
         if (r < a) r = a;
         if (r > b) r = b;
      end else begin
         if (r < b) r = b;
         if (r > a) r = a;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] deadband(input logic signed [31:0] v);
      logic signed [31:0] r;
      r = v;
      if (v > -DEADBAND && v < DEADBAND) begin
         r = '0;
      end
      return r;
   endfunction

   // arctangent of 2^-i in Q16.16 degrees
   function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
      logic signed [25:0] r;
      case (i)
         4'd0:  r = 26'sd2949120;
         4'd1:  r = 26'sd1740967;
         4'd2:  r = 26'sd919879;
         4'd3:  r = 26'sd466945;
         4'd4:  r = 26'sd234379;
         4'd5:  r = 26'sd117304;
         4'd6:  r = 26'sd58666;
         4'd7:  r = 26'sd29335;
         4'd8:  r = 26'sd14668;
         4'd9:  r = 26'sd7334;
         4'd10: r = 26'sd3667;
         4'd11: r = 26'sd1833;
         4'd12: r = 26'sd917;
         4'd13: r = 26'sd458;
         4'd14: r = 26'sd229;
         4'd15: r = 26'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hw/rtl/vks_sequencer.sv =====
// Microcode sequencer: program ROM, step counter, loop counter and jump logic
module vks_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  vks_pkg::cond_type           cond,
   output vks_pkg::ctl_word_type       ctl,
   output logic [vks_pkg::CNT_W-1:0]   cnt
);
   import vks_pkg::*;

   logic [PC_W-1:0]  pc_ff, pc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   function automatic ctl_word_type rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      case (pc)
         5'd0:  w = '{MUL_NONE,    ALU_NOP,        J_WAIT_REQ, PC_LAG};
         5'd1:  w = '{MUL_LAG_SPD, ALU_NOP,        J_IF_KIND0, PC_CLAMP};
         5'd2:  w = '{MUL_LAG_STR, ALU_LAG_SPD,    J_NEXT,     PC_IDLE};
         5'd3:  w = '{MUL_NONE,    ALU_LAG_STR,    J_NEXT,     PC_IDLE};
         5'd4:  w = '{MUL_NONE,    ALU_CLAMP_INIT, J_NEXT,     PC_IDLE};
         5'd5:  w = '{MUL_SPD_DT,  ALU_NOP,        J_NEXT,     PC_IDLE};
         5'd6:  w = '{MUL_TURN,    ALU_D_LOAD,     J_NEXT,     PC_IDLE};
         5'd7:  w = '{MUL_NONE,    ALU_T1_LOAD,    J_NEXT,     PC_IDLE};
         5'd8:  w = '{MUL_TURN_LO, ALU_NOP,        J_NEXT,     PC_IDLE};
         5'd9:  w = '{MUL_TURN_HI, ALU_ACC_LO,     J_NEXT,     PC_IDLE};
         5'd10: w = '{MUL_NONE,    ALU_ACC_HI,     J_NEXT,     PC_IDLE};
         5'd11: w = '{MUL_NONE,    ALU_HEAD_ADD,   J_NEXT,     PC_IDLE};
         5'd12: w = '{MUL_NONE,    ALU_WRAP_INIT,  J_NEXT,     PC_IDLE};
         5'd13: w = '{MUL_NONE,    ALU_ITER,       J_LOOP,     PC_ITER};
         5'd14: w = '{MUL_XC,      ALU_HEAD_FIX,   J_NEXT,     PC_IDLE};
         5'd15: w = '{MUL_ZS,      ALU_X_ACC,      J_NEXT,     PC_IDLE};
         5'd16: w = '{MUL_NONE,    ALU_Z_ACC,      J_NEXT,     PC_IDLE};
         5'd17: w = '{MUL_NONE,    ALU_FINISH,     J_WAIT_OUT, PC_IDLE};
         default: w = '{MUL_NONE,  ALU_NOP,        J_GOTO,     PC_IDLE};
      endcase
      return w;
   endfunction

   assign ctl = rom(pc_ff);
   assign cnt = cnt_ff;

   always_comb begin
      pc_in  = pc_ff + 5'd1;
      cnt_in = '0;
      case (ctl.jump)
         J_NEXT:     pc_in = pc_ff + 5'd1;
         J_GOTO:     pc_in = ctl.target;
         J_IF_KIND0: pc_in = cond.kind0 ? ctl.target : pc_ff + 5'd1;
         J_LOOP: begin
            if (cnt_ff != LOOP_LAST) begin
               pc_in  = ctl.target;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         J_WAIT_REQ: pc_in = cond.req_valid ? ctl.target : pc_ff;
         J_WAIT_OUT: pc_in = cond.out_free ? ctl.target : pc_ff;
         default:    pc_in = PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= PC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LAST)
      else $error("step counter beyond end of program");

   a_cnt_in_loop: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (pc_ff == PC_ITER))
      else $error("loop counter live outside iteration step");

   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == PC_ITER && cnt_ff == LOOP_LAST) |=> (pc_ff != PC_ITER && cnt_ff == '0))
      else $error("iteration loop failed to exit");

endmodule

// ===== hw/rtl/vehicle_kinematic_step_core.sv =====
// Kinematic vehicle step core: datapath, APB registers and result register
// One word in gives one word out. A word with kind 0 skips the lag steps and so is done
// sooner than one with kind 1. Most of the work lies in the 24-pass iteration step, in
// which the 16 CORDIC rotations and the restoring heading-wrap remainder share one loop
// of a microcoded sequencer around a single 34x34 multiplier. One word is in flight at a
// time; the next is taken as soon as the sequencer is back at idle, even while the last
// result still waits in the output register. Completion stalls only when a second result
// is ready before the first is taken. Limit registers are written over the APB port; the
// user must write them only while the core is idle, which the block does not enforce.
// pready is always high.
module vehicle_kinematic_step_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  vks_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output vks_pkg::rsp_type             rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vks_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import vks_pkg::*;

   typedef enum logic [1:0] {
      WRAP_KEEP,
      WRAP_POS,
      WRAP_NEG
   } wrap_type;

   ctl_word_type      ctl;
   cond_type          cond;
   logic [CNT_W-1:0]  cnt;

   logic signed [31:0] fwd_ff, fwd_in, bwd_ff, bwd_in;
   logic signed [31:0] left_ff, left_in, right_ff, right_in;
   logic signed [31:0] speed_ff, speed_in, steer_ff, steer_in;
   logic signed [31:0] x_ff, x_in, z_ff, z_in;
   logic [24:0]        heading_ff, heading_in;
   req_type            item_ff, item_in;
   logic signed [67:0] prod_ff, prod_in;
   logic signed [32:0] d_ff, d_in;
   logic               neg_ff, neg_in;
   logic signed [47:0] t1_ff, t1_in;
   logic signed [65:0] acc_ff, acc_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] ang_ff, ang_in;
   logic [48:0]        rem_ff, rem_in;
   logic signed [48:0] hsum_ff, hsum_in;
   wrap_type           wmode_ff, wmode_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [52:0] p53, g53;
   logic signed [39:0] lag_sum, x_sum, z_sum;
   logic signed [25:0] h_fold, at_v;
   logic signed [33:0] cx_sh, cy_sh;
   logic signed [32:0] ds;
   logic [CNT_W-1:0]   shamt;
   logic [48:0]        rem_sub;
   logic signed [48:0] hs_lim;
   logic signed [31:0] db_speed, db_steer;
   logic               out_free, rsp_load, csr_wr, req_fire;

   vks_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctl   (ctl),
      .cnt   (cnt)
   );

   assign req_ready  = (ctl.jump == J_WAIT_REQ);
   assign req_fire   = req_valid & req_ready;
   assign out_free   = ~rsp_valid_ff | rsp_ready;
   assign rsp_load   = (ctl.alu_op == ALU_FINISH) & out_free;
   assign cond       = '{req_valid: req_valid, kind0: ~item_ff.kind, out_free: out_free};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      case (csr_reg_type'(csr_paddr[3:2]))
         REG_FWD_SPEED:   csr_prdata = fwd_ff;
         REG_BWD_SPEED:   csr_prdata = bwd_ff;
         REG_LEFT_STEER:  csr_prdata = left_ff;
         REG_RIGHT_STEER: csr_prdata = right_ff;
         default:         csr_prdata = '0;
      endcase
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.mul_sel)
         MUL_LAG_SPD: begin
            mul_a = 34'(item_ff.target_speed) - 34'(speed_ff);
            mul_b = $signed({18'b0, item_ff.time_step});
         end
         MUL_LAG_STR: begin
            mul_a = 34'(item_ff.target_steering) - 34'(steer_ff);
            mul_b = $signed({18'b0, item_ff.time_step});
         end
         MUL_SPD_DT: begin
            mul_a = 34'(speed_ff);
            mul_b = $signed({18'b0, item_ff.time_step});
         end
         MUL_TURN: begin
            mul_a = 34'(steer_ff);
            mul_b = 34'(speed_ff);
         end
         MUL_TURN_LO: begin
            mul_a = $signed({10'b0, t1_ff[23:0]});
            mul_b = $signed({18'b0, item_ff.time_step});
         end
         MUL_TURN_HI: begin
            mul_a = 34'($signed(t1_ff[47:24]));
            mul_b = $signed({18'b0, item_ff.time_step});
         end
         MUL_XC: begin
            mul_a = 34'(d_ff);
            mul_b = cx_ff;
         end
         MUL_ZS: begin
            mul_a = 34'(d_ff);
            mul_b = cy_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // datapath
   always_comb begin
      fwd_in     = fwd_ff;
      bwd_in     = bwd_ff;
      left_in    = left_ff;
      right_in   = right_ff;
      speed_in   = speed_ff;
      steer_in   = steer_ff;
      x_in       = x_ff;
      z_in       = z_ff;
      heading_in = heading_ff;
      item_in    = item_ff;
      d_in       = d_ff;
      neg_in     = neg_ff;
      t1_in      = t1_ff;
      acc_in     = acc_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      ang_in     = ang_ff;
      rem_in     = rem_ff;
      hsum_in    = hsum_ff;
      wmode_in   = wmode_ff;
      rsp_in     = rsp_ff;

      p53      = $signed(prod_ff[52:0]);
      g53      = (ctl.alu_op == ALU_LAG_STR) ? (p53 <<< 2) + (p53 <<< 1) : p53 <<< 2;
      lag_sum  = (ctl.alu_op == ALU_LAG_STR) ? 40'(steer_ff) + 40'(g53 >>> 16)
                                              : 40'(speed_ff) + 40'(g53 >>> 16);
      h_fold   = $signed({1'b0, heading_ff});
      ds       = $signed(prod_ff[48:16]);
      cx_sh    = cx_ff >>> cnt[3:0];
      cy_sh    = cy_ff >>> cnt[3:0];
      at_v     = atan_deg(cnt[3:0]);
      shamt    = LOOP_LAST - cnt;
      rem_sub  = {24'b0, DEG360} << shamt;
      hs_lim   = $signed({24'b0, DEG360});
      x_sum    = 40'(x_ff) + 40'($signed(prod_ff[67:30]));
      z_sum    = 40'(z_ff) + 40'($signed(prod_ff[67:30]));
      db_speed = deadband(speed_ff);
      db_steer = deadband(steer_ff);

      if (csr_wr) begin
         case (csr_reg_type'(csr_paddr[3:2]))
            REG_FWD_SPEED:   fwd_in   = $signed(csr_pwdata);
            REG_BWD_SPEED:   bwd_in   = $signed(csr_pwdata);
            REG_LEFT_STEER:  left_in  = $signed(csr_pwdata);
            REG_RIGHT_STEER: right_in = $signed(csr_pwdata);
            default: ;
         endcase
      end

      if (req_fire) begin
         item_in = req_data;
      end

      case (ctl.alu_op)
         ALU_LAG_SPD: speed_in = sat32(lag_sum);
         ALU_LAG_STR: steer_in = sat32(lag_sum);
         ALU_CLAMP_INIT: begin
            speed_in = limit(bwd_ff, speed_ff, fwd_ff);
            steer_in = limit(left_ff, steer_ff, right_ff);
            cx_in    = CORDIC_K;
            cy_in    = '0;
            if (h_fold <= DEG90_S) begin
               ang_in = h_fold;
               neg_in = 1'b0;
            end else if (h_fold <= DEG270_S) begin
               ang_in = h_fold - DEG180_S;
               neg_in = 1'b1;
            end else begin
               ang_in = h_fold - DEG360_S;
               neg_in = 1'b0;
            end
         end
         // fold the half-turn sign into the travel distance
         ALU_D_LOAD:  d_in  = neg_ff ? -ds : ds;
         ALU_T1_LOAD: t1_in = $signed(prod_ff[63:16]);
         ALU_ACC_LO:  acc_in = $signed(prod_ff[65:0]);
         ALU_ACC_HI:  acc_in = acc_ff + $signed({prod_ff[41:0], 24'b0});
         ALU_HEAD_ADD: hsum_in = 49'(h_fold) + $signed(acc_ff[64:16]);
         ALU_WRAP_INIT: begin
            if (hsum_ff > hs_lim) begin
               wmode_in = WRAP_POS;
               rem_in   = hsum_ff - 49'sd1;
            end else if (hsum_ff < 49'sd0) begin
               wmode_in = WRAP_NEG;
               rem_in   = -hsum_ff;
            end else begin
               wmode_in = WRAP_KEEP;
               rem_in   = hsum_ff;
            end
         end
         ALU_ITER: begin
            if (cnt < CORDIC_STEPS) begin
               if (!ang_ff[25]) begin
                  cx_in  = cx_ff - cy_sh;
                  cy_in  = cy_ff + cx_sh;
                  ang_in = ang_ff - at_v;
               end else begin
                  cx_in  = cx_ff + cy_sh;
                  cy_in  = cy_ff - cx_sh;
                  ang_in = ang_ff + at_v;
               end
            end
            if (rem_ff >= rem_sub) begin
               rem_in = rem_ff - rem_sub;
            end
         end
         ALU_HEAD_FIX: begin
            case (wmode_ff)
               WRAP_POS: heading_in = rem_ff[24:0] + 25'd1;
               WRAP_NEG: heading_in = (rem_ff[24:0] == '0) ? '0 : DEG360 - rem_ff[24:0];
               default:  heading_in = hsum_ff[24:0];
            endcase
         end
         ALU_X_ACC: x_in = sat32(x_sum);
         ALU_Z_ACC: z_in = sat32(z_sum);
         ALU_FINISH: begin
            if (out_free) begin
               speed_in = db_speed;
               steer_in = db_steer;
               rsp_in   = '{pos_x: x_ff, pos_z: z_ff, heading: heading_ff,
                            cur_speed: db_speed, cur_steering: db_steer};
            end
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff       <= RST_FWD_SPEED;
         bwd_ff       <= RST_BWD_SPEED;
         left_ff      <= RST_LEFT_STEER;
         right_ff     <= RST_RIGHT_STEER;
         speed_ff     <= '0;
         steer_ff     <= '0;
         x_ff         <= '0;
         z_ff         <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fwd_ff       <= fwd_in;
         bwd_ff       <= bwd_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         speed_ff     <= speed_in;
         steer_ff     <= steer_in;
         x_ff         <= x_in;
         z_ff         <= z_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      d_ff     <= d_in;
      neg_ff   <= neg_in;
      t1_ff    <= t1_in;
      acc_ff   <= acc_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      ang_ff   <= ang_in;
      rem_ff   <= rem_in;
      hsum_ff  <= hsum_in;
      wmode_ff <= wmode_in;
      rsp_ff   <= rsp_in;
   end

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.heading <= DEG360))
      else $error("heading outside 0 to 360");

   a_speed_deadband: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.cur_speed == '0 || rsp_ff.cur_speed >= DEADBAND ||
                        rsp_ff.cur_speed <= -DEADBAND))
      else $error("speed inside deadband");

   a_steer_deadband: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.cur_steering == '0 || rsp_ff.cur_steering >= DEADBAND ||
                        rsp_ff.cur_steering <= -DEADBAND))
      else $error("steering inside deadband");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_ff))
      else $error("pending result overwritten");

endmodule
